@@ design/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 edge-aware box blur
// Pixel, column and line-store word types, configuration register indexes,
// item codes and the reciprocal table used by the rounding divider.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;
    localparam int HEIGHT_CAP         = 4096;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int OUT_ROW_W      = 12;
    localparam int CHAN_W         = 8;
    localparam int SUM_W          = 12;
    localparam int COUNT_W        = 4;
    localparam int RECIP_W        = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Index 2 is red, 1 is green, 0 is blue.
    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [2:0] rgb_t;

    // Index 0 is the oldest row, index 2 the row being received.
    typedef rgb_t [2:0] col_t;

    typedef struct packed {
        rgb_t older;
        rgb_t newer;
    } line_word_t;

    typedef logic [SUM_W-1:0] chan_sum_t;
    typedef chan_sum_t [2:0] rgb_sum_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [COUNT_W-1:0] count;
    } avg_ctl_t;

    // floor(65536 / (2 * count)) for the tap counts that can occur.
    function automatic logic [RECIP_W-1:0] avg_recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] recip;
        case (count)
            4'd1:    recip = 16'd32768;
            4'd2:    recip = 16'd16384;
            4'd3:    recip = 16'd10922;
            4'd4:    recip = 16'd8192;
            4'd6:    recip = 16'd5461;
            4'd9:    recip = 16'd3640;
            default: recip = 16'd0;
        endcase
        return recip;
    endfunction

endpackage

@@ design/bb3_round_div.sv @@
// ----------------------------------------------------------------------------
// bb3_round_div: rounded division of three channel sums by the tap count
// Forms (2*sum + n) / (2*n) with a reciprocal multiply, registers the
// estimate, then corrects it by one using a remainder compare.
// ----------------------------------------------------------------------------
module bb3_round_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  bb3_pkg::avg_ctl_t ctl,
    input  bb3_pkg::rgb_sum_t sums,
    output logic              done_valid,
    output logic              done_last,
    output bb3_pkg::rgb_t     quotient
);
    import bb3_pkg::*;

    localparam int V_W = SUM_W + 1;
    localparam int P_W = V_W + RECIP_W;

    logic [RECIP_W-1:0]        recip;
    logic [2:0][V_W-1:0]       dividend;
    logic [2:0][P_W-1:0]       product;
    rgb_t                      estimate;

    logic                      valid_reg;
    logic                      last_reg;
    logic [COUNT_W:0]          divisor_reg;
    logic [2:0][V_W-1:0]       dividend_reg;
    rgb_t                      estimate_reg;

    logic [2:0][V_W-1:0]       back_product;
    logic [2:0][V_W-1:0]       remainder;

    always_comb
    begin
        recip = avg_recip(ctl.count);
        for (int ch = 0; ch < 3; ch++)
        begin
            dividend[ch] = {sums[ch], 1'b0} + V_W'(ctl.count);
            product[ch]  = P_W'(dividend[ch]) * P_W'(recip);
            // The estimate never exceeds the true quotient, which is at most 255.
            estimate[ch] = product[ch][RECIP_W +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg     <= ctl.last;
            divisor_reg  <= {ctl.count, 1'b0};
            dividend_reg <= dividend;
            estimate_reg <= estimate;
        end
    end

    // The estimate is the quotient or one below it.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            back_product[ch] = V_W'(estimate_reg[ch]) * V_W'(divisor_reg);
            remainder[ch]    = dividend_reg[ch] - back_product[ch];
            quotient[ch]     = (remainder[ch] >= V_W'(divisor_reg))
                             ? estimate_reg[ch] + CHAN_W'(1) : estimate_reg[ch];
        end
    end

    assign done_valid = valid_reg;
    assign done_last  = last_reg;

endmodule

@@ design/box_blur_3x3_edge_aware_top.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top: streaming 3x3 box blur of RGB pixels
// Two line stores held in one synchronous memory, a 3x3 window of registers
// and a pipelined rounding divider produce the edge-aware neighbourhood mean.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the item channel (item_valid/item_ready);
// op selects a pixel or a drain item. Blurred pixels leave on the result
// channel (result_valid/result_ready), each channel the rounded mean of the
// neighbours that lie inside the frame, so the divisor is 4, 6 or 9 (fewer on
// one-pixel-wide or one-pixel-high frames). The output for a pixel is caused
// by the item one row and one pixel later; after the frame's last pixel,
// frame_width + 1 further items (drain items, or pixels whose data is then
// discarded) flush the remaining outputs. frame_last marks the final output,
// after which the next item starts a new frame. Drain items before the last
// pixel are accepted and ignored.
// An item is taken every cycle while the result side is not stalled; a
// result is offered once the item that causes it has passed the memory
// read, window/sum, reciprocal multiply and output register stages, the
// first of which it enters at the edge that accepts it.
// A stalled receiver holds the output register and with it the whole
// pipeline, so item_ready falls until the waiting result is taken.
// Reset gives a 640 x 480 frame and an empty frame in progress. Writing
// either register through cfg_write also restarts the frame; write only
// while no item is in flight. The line stores are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    // item channel
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             op,
    input  logic [bb3_pkg::CHAN_W-1:0]       red,
    input  logic [bb3_pkg::CHAN_W-1:0]       green,
    input  logic [bb3_pkg::CHAN_W-1:0]       blue,
    // result channel
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [bb3_pkg::CHAN_W-1:0]       out_red,
    output logic [bb3_pkg::CHAN_W-1:0]       out_green,
    output logic [bb3_pkg::CHAN_W-1:0]       out_blue,
    output logic                             frame_last
);
    import bb3_pkg::*;

    localparam int AW          = $clog2(MAX_WIDTH);
    localparam int EW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = FRAME_HEIGHT_W;
    localparam int EFF_W_RESET = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                 : FRAME_WIDTH_RESET;

    // ------------------------------------------------------------------
    // Frame geometry, held already clamped to the supported range.
    // ------------------------------------------------------------------
    logic [EW-1:0]        eff_w_reg;
    logic [EW-1:0]        eff_w_next;
    logic [HW-1:0]        eff_h_reg;
    logic [HW-1:0]        eff_h_next;
    logic [31:0]          cfg_w_raw;
    logic [31:0]          cfg_h_raw;

    // Input and output raster positions.
    logic [AW-1:0]        in_col_reg;
    logic [AW-1:0]        in_col_next;
    logic [HW-1:0]        in_row_reg;
    logic [HW-1:0]        in_row_next;
    logic [AW-1:0]        out_col_reg;
    logic [AW-1:0]        out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_ROW_W-1:0] out_row_next;

    // Acceptance decode.
    logic                 advance;
    logic                 accept;
    logic                 draining;
    logic                 take;
    logic                 emit;
    logic                 right_edge;
    logic                 row_last;
    logic                 frame_end;
    rgb_t                 in_pixel;
    logic [EW-1:0]        in_col_inc;
    logic [EW-1:0]        out_col_inc;

    // Stage 1: item waiting for its line store word.
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic [AW-1:0]        s1_x_reg;
    rgb_t                 s1_pixel_reg;
    logic                 s1_col_first_reg;
    logic                 s1_right_edge_reg;
    logic                 s1_row_first_reg;
    logic                 s1_row_last_reg;
    logic                 s1_last_reg;

    // Line store memory and forwarding of the most recent write.
    line_word_t           line_mem [MAX_WIDTH];
    line_word_t           mem_rd_reg;
    logic                 fwd_valid_reg;
    logic [AW-1:0]        fwd_addr_reg;
    line_word_t           fwd_data_reg;
    line_word_t           line_rd;
    line_word_t           line_wr;

    // Window and neighbourhood sums.
    col_t [2:0]           win_reg;
    col_t                 new_col;
    col_t [2:0]           taps;
    logic [2:0]           col_en;
    logic [2:0]           row_en;
    logic [1:0]           col_count;
    logic [1:0]           row_count;
    rgb_sum_t             sums;

    // Stage 2: sums on their way into the divider.
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [COUNT_W-1:0]   s2_count_reg;
    logic [COUNT_W-1:0]   count;
    rgb_sum_t             s2_sums_reg;
    avg_ctl_t             div_ctl;

    // Divider results and the output register.
    logic                 div_valid;
    logic                 div_last;
    rgb_t                 div_quotient;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    rgb_t                 out_pix_reg;

    // ------------------------------------------------------------------
    // Handshake. The whole pipeline moves whenever the output register
    // is free or being emptied.
    // ------------------------------------------------------------------
    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = advance;
    assign accept     = item_valid && item_ready;

    // Once the frame's last pixel has gone in, every item flushes; a drain
    // item before that point changes nothing and gives no result.
    assign draining   = in_row_reg >= eff_h_reg;
    assign take       = accept && (draining || op != OP_DRAIN);
    assign in_pixel   = draining ? rgb_t'('0) : rgb_t'({red, green, blue});

    // An output becomes due once its whole lower neighbour row is present.
    assign emit       = (in_row_reg > HW'(1)) || (in_row_reg == HW'(1) && in_col_reg != '0);
    assign right_edge = (EW'(out_col_reg) + EW'(1)) == eff_w_reg;
    assign row_last   = (HW'(out_row_reg) + HW'(1)) >= eff_h_reg;
    assign frame_end  = right_edge && row_last;

    assign in_col_inc  = EW'(in_col_reg) + EW'(1);
    assign out_col_inc = EW'(out_col_reg) + EW'(1);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take)
        begin
            if (in_col_inc == eff_w_reg)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = in_col_inc[AW-1:0];
            end
            if (emit)
            begin
                if (frame_end)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (right_edge)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_inc[AW-1:0];
                end
            end
        end
    end

    // Clamp written geometry: zero acts as one, oversize as the limit.
    always_comb
    begin
        cfg_w_raw = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
        cfg_h_raw = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);
        if (cfg_w_raw == 32'd0)
        begin
            eff_w_next = EW'(1);
        end
        else if (cfg_w_raw > 32'(MAX_WIDTH))
        begin
            eff_w_next = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w_next = EW'(cfg_w_raw);
        end
        if (cfg_h_raw == 32'd0)
        begin
            eff_h_next = HW'(1);
        end
        else if (cfg_h_raw > 32'(HEIGHT_CAP))
        begin
            eff_h_next = HW'(HEIGHT_CAP);
        end
        else
        begin
            eff_h_next = HW'(cfg_h_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg   <= EW'(EFF_W_RESET);
            eff_h_reg   <= HW'(FRAME_HEIGHT_RESET);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  eff_w_reg <= eff_w_next;
                CFG_FRAME_HEIGHT: eff_h_reg <= eff_h_next;
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 register: the item whose line store word is being read.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_emit_reg       <= emit;
            s1_x_reg          <= in_col_reg;
            s1_pixel_reg      <= in_pixel;
            s1_col_first_reg  <= (out_col_reg == '0);
            s1_right_edge_reg <= right_edge;
            s1_row_first_reg  <= (out_row_reg == '0);
            s1_row_last_reg   <= row_last;
            s1_last_reg       <= frame_end;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one word per column holds the two previous rows. The
    // word is read as the item is accepted and written back, shifted by a
    // row, as it leaves stage 1. On a one-column frame consecutive items
    // share a column, so the last write is forwarded over the read data.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mem_rd_reg <= line_mem[in_col_reg];
        end
        if (s1_valid_reg && advance)
        begin
            line_mem[s1_x_reg] <= line_wr;
        end
    end

    assign line_rd = (fwd_valid_reg && fwd_addr_reg == s1_x_reg) ? fwd_data_reg : mem_rd_reg;
    assign line_wr = '{older: line_rd.newer, newer: s1_pixel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && advance)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            fwd_addr_reg <= s1_x_reg;
            fwd_data_reg <= line_wr;
        end
    end

    // ------------------------------------------------------------------
    // Window. The neighbourhood of the pending output is always the two
    // newest window columns plus the column arriving now; at the right edge
    // the arriving column belongs to the next row and is left out.
    // ------------------------------------------------------------------
    always_comb
    begin
        new_col[0] = line_rd.older;
        new_col[1] = line_rd.newer;
        new_col[2] = s1_pixel_reg;
        taps[0]    = win_reg[1];
        taps[1]    = win_reg[2];
        taps[2]    = new_col;
        col_en     = {!s1_right_edge_reg, 1'b1, !s1_col_first_reg};
        row_en     = {!s1_row_last_reg, 1'b1, !s1_row_first_reg};
        col_count  = 2'd1 + 2'(col_en[0]) + 2'(col_en[2]);
        row_count  = 2'd1 + 2'(row_en[0]) + 2'(row_en[2]);
        count      = COUNT_W'(col_count) * COUNT_W'(row_count);
        for (int ch = 0; ch < 3; ch++)
        begin
            sums[ch] = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (col_en[c] && row_en[r])
                    begin
                        sums[ch] = sums[ch] + SUM_W'(taps[c][r][ch]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg_write)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= new_col;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 register and divider.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_count_reg <= count;
            s2_sums_reg  <= sums;
        end
    end

    assign div_ctl = '{valid: s2_valid_reg, last: s2_last_reg, count: s2_count_reg};

    bb3_round_div u_round_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .ctl        (div_ctl),
        .sums       (s2_sums_reg),
        .done_valid (div_valid),
        .done_last  (div_last),
        .quotient   (div_quotient)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= div_last;
            out_pix_reg  <= div_quotient;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_red      = out_pix_reg[2];
    assign out_green    = out_pix_reg[1];
    assign out_blue     = out_pix_reg[0];
    assign frame_last   = out_last_reg;

`ifndef ASSERT_OFF
    // The input column always lies inside the current frame width.
    a_in_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(in_col_reg) < eff_w_reg)
        else $error("input column beyond frame width");

    // The output row never passes the last row of the frame.
    a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        HW'(out_row_reg) < eff_h_reg)
        else $error("output row beyond frame height");

    // Flushing ends with the final output, so the input row never exceeds the frame height plus one.
    a_in_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (HW + 1)'(in_row_reg) <= (HW + 1)'(eff_h_reg) + (HW + 1)'(1))
        else $error("flush ran past the final output");

    // The item that causes the frame's final output restarts all positions.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit && frame_end && !cfg_write |=>
            in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0)
        else $error("positions not cleared at frame end");
`endif

endmodule

@@ dv/box_blur_3x3_edge_aware_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top_tb: self-checking bench of the 3x3 RGB box blur
// Streams raster-order frames of many sizes through the item channel, predicts
// every blurred pixel with an independent line-store and window model, and
// compares each result field by field under idle, stall and back-pressure.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top_tb;

    import bb3_pkg::*;

    // The pipeline is four stages deep; a drain item that yields nothing can
    // still be in flight when the last expected pixel has arrived, so this
    // many idle cycles pass before any register write.
    localparam int PIPE_SETTLE    = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_W          = MAX_WIDTH_DEFAULT;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  last;
    } blur_px_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the inputs of the block, all known from time zero.
    // ------------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  op           = OP_PIXEL;
    chan_t                 red          = '0;
    chan_t                 green        = '0;
    chan_t                 blue         = '0;
    logic                  result_ready = 1'b0;

    logic                  item_ready;
    logic                  result_valid;
    chan_t                 out_red;
    chan_t                 out_green;
    chan_t                 out_blue;
    logic                  frame_last;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    box_blur_3x3_edge_aware_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .frame_last   (frame_last)
    );

    // ------------------------------------------------------------------------
    // Bench state: pacing knobs, the queue of predicted pixels and counters.
    // ------------------------------------------------------------------------
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    bit          long_hold_req  = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    blur_px_t    pending_blur_q[$];
    int unsigned stream_items    = 0;
    int unsigned blurred_checked = 0;
    int unsigned frames_closed   = 0;
    int unsigned mismatch_count  = 0;

    // ------------------------------------------------------------------------
    // Blur predictor. It keeps its own copy of the frame geometry, the two
    // line stores, the 3x3 window and the input and output raster positions.
    // The window is held column-major: tap index is column * 3 + row, with
    // column 2 the newest and row 2 the row currently arriving.
    // ------------------------------------------------------------------------
    logic [FRAME_WIDTH_W-1:0]  cfg_width;
    logic [FRAME_HEIGHT_W-1:0] cfg_height;
    logic [23:0]               line_older [MAX_W];
    logic [23:0]               line_newer [MAX_W];
    logic [23:0]               win_taps [9];
    int unsigned               in_col;
    int unsigned               in_row;
    int unsigned               out_col;
    int unsigned               out_row;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(cfg_width);
        if (w == 0)
            w = 1;
        if (w > MAX_W)
            w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(cfg_height);
        if (h == 0)
            h = 1;
        if (h > HEIGHT_CAP)
            h = HEIGHT_CAP;
        return h;
    endfunction

    function automatic void restart_frame();
        int i;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        for (i = 0; i < 9; i++)
            win_taps[i] = '0;
    endfunction

    // Advances the predictor by one accepted item. Returns 1 when the item
    // took part in the frame, 0 when it was an early drain and was ignored.
    // Any blurred pixel that the item releases is queued for checking.
    function automatic bit blur_predict(input logic item_op, input chan_t r,
                                        input chan_t g, input chan_t b);
        int unsigned w, h, x, y, c, rw, n, sr, sg, sb, centre;
        int          i, dc, dr;
        logic [23:0] px, older, newer, tap;
        logic [23:0] prior [9];
        logic [23:0] sel [9];
        bit          draining, right_edge;
        blur_px_t    want;
        w = eff_width();
        h = eff_height();
        draining = (in_row >= h);
        if (!draining && item_op == OP_DRAIN)
            return 1'b0;
        // Once the last pixel is in, any item only flushes; its data is lost.
        px = draining ? 24'h0 : {r, g, b};

        x = in_col;
        y = in_row;
        if (x >= MAX_W)
            x = MAX_W - 1;
        older = line_older[x];
        newer = line_newer[x];
        line_older[x] = newer;
        line_newer[x] = px;

        prior = win_taps;
        for (i = 0; i < 6; i++)
            win_taps[i] = win_taps[i + 3];
        win_taps[6] = older;
        win_taps[7] = newer;
        win_taps[8] = px;

        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end

        // The first output needs one full row and one pixel of look-ahead.
        if (!((y > 1) || (y == 1 && x >= 1)))
            return 1'b1;

        c  = out_col;
        rw = out_row;
        right_edge = (c + 1 == w);
        // At the right edge the centre column is the one before the shift.
        if (right_edge)
        begin
            sel    = prior;
            centre = 2;
        end
        else
        begin
            sel    = win_taps;
            centre = 1;
        end

        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (dc = -1; dc <= 1; dc++)
        begin
            if ((dc < 0 && c == 0) || (dc > 0 && right_edge))
                continue;
            for (dr = -1; dr <= 1; dr++)
            begin
                if ((dr < 0 && rw == 0) || (dr > 0 && rw + 1 >= h))
                    continue;
                tap = sel[(int'(centre) + dc) * 3 + dr + 1];
                sr += 32'(tap[23:16]);
                sg += 32'(tap[15:8]);
                sb += 32'(tap[7:0]);
                n++;
            end
        end

        // Half-up rounding of the mean: (2 * sum + n) / (2 * n).
        want.red   = 8'((2 * sr + n) / (2 * n));
        want.green = 8'((2 * sg + n) / (2 * n));
        want.blue  = 8'((2 * sb + n) / (2 * n));
        want.last  = right_edge && (rw + 1 >= h);
        pending_blur_q.push_back(want);

        if (want.last)
        begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the receiver pacing process, the checker and the watchdog.
    // ------------------------------------------------------------------------

    // The receiver is ready at random, or held off for a long stretch on
    // request; the stretch is counted here so the sender can keep going.
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left--;
        end
        else
            result_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_blur_result();
        blur_px_t want;
        if (pending_blur_q.size() == 0)
        begin
            flag_mismatch($sformatf("blurred pixel %0d,%0d,%0d last=%0b with none predicted",
                                    out_red, out_green, out_blue, frame_last));
            return;
        end
        want = pending_blur_q.pop_front();
        if (out_red !== want.red)
            flag_mismatch($sformatf("pixel %0d out_red %0d, predicted %0d",
                                    blurred_checked, out_red, want.red));
        if (out_green !== want.green)
            flag_mismatch($sformatf("pixel %0d out_green %0d, predicted %0d",
                                    blurred_checked, out_green, want.green));
        if (out_blue !== want.blue)
            flag_mismatch($sformatf("pixel %0d out_blue %0d, predicted %0d",
                                    blurred_checked, out_blue, want.blue));
        if (frame_last !== want.last)
            flag_mismatch($sformatf("pixel %0d frame_last %0b, predicted %0b",
                                    blurred_checked, frame_last, want.last));
        if (want.last)
            frames_closed++;
        blurred_checked++;
    endtask

    // Values are sampled at the edge, before the nonblocking updates land,
    // so every process sees the same handshake.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && result_valid && result_ready)
            check_blur_result();
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("box_blur_3x3_edge_aware_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Channel values lean towards the extremes so that saturated sums occur.
    function automatic chan_t rand_chan();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offers one item, holding it steady until it is taken, then advances the
    // predictor. Valid is left high so that back-to-back items need no gap.
    task automatic push_item(input logic item_op, input chan_t r, input chan_t g,
                             input chan_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= item_op;
        red        <= r;
        green      <= g;
        blue       <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (blur_predict(item_op, r, g, b))
            stream_items++;
    endtask

    task automatic push_random(input logic item_op);
        push_item(item_op, rand_chan(), rand_chan(), rand_chan());
    endtask

    // Stops offering and waits until every predicted pixel has been seen.
    task automatic wait_blur_drained();
        item_valid <= 1'b0;
        while (pending_blur_q.size() != 0)
            @(posedge clk);
    endtask

    // Registers are only written with the pipeline empty. A write restarts
    // the frame, in the block and in the predictor alike.
    task automatic write_frame_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_blur_drained();
        repeat (PIPE_SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            cfg_width = value[FRAME_WIDTH_W-1:0];
        else
            cfg_height = value[FRAME_HEIGHT_W-1:0];
        restart_frame();
    endtask

    task automatic set_geometry(input int w, input int h);
        write_frame_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_frame_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Sends one frame of random pixels, with early drain items mixed in as
    // noise, then the width-plus-one flush items (a mix of drain items and
    // pixels whose data is thrown away). A broken frame stops part-way and
    // sends no flush.
    task automatic send_frame(input int unsigned noise_pct, input bit broken);
        int unsigned w, total, stop_at, k;
        w       = eff_width();
        total   = w * eff_height();
        stop_at = broken ? $urandom_range(total - 1) : total;
        for (k = 0; k < stop_at; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_random(OP_DRAIN);
            push_random(OP_PIXEL);
        end
        if (!broken)
            for (k = 0; k <= w; k++)
                push_random($urandom_range(1) ? OP_DRAIN : OP_PIXEL);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A 3x2 frame of extreme colours: corners divide by 4, edges by 6. An
    // early drain item sits inside the frame and must be ignored; a pixel in
    // the flush must have its data discarded. Then zero width and zero height,
    // which act as a single-pixel frame.
    task automatic test_corner_pixels();
        set_geometry(3, 2);
        push_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        push_item(OP_PIXEL, 8'd0,   8'd0,   8'd0);
        push_item(OP_DRAIN, 8'd255, 8'd255, 8'd255);
        push_item(OP_PIXEL, 8'd255, 8'd0,   8'd255);
        push_item(OP_PIXEL, 8'd0,   8'd255, 8'd0);
        push_item(OP_PIXEL, 8'd1,   8'd128, 8'd254);
        push_item(OP_PIXEL, 8'd255, 8'd255, 8'd0);
        push_item(OP_DRAIN, 8'd0,   8'd0,   8'd0);
        push_item(OP_PIXEL, 8'd12,  8'd34,  8'd56);
        push_item(OP_DRAIN, 8'd0,   8'd0,   8'd0);
        push_item(OP_DRAIN, 8'd0,   8'd0,   8'd0);

        set_geometry(0, 0);
        push_item(OP_PIXEL, 8'd255, 8'd0, 8'd128);
        push_item(OP_DRAIN, 8'd0,   8'd0, 8'd0);
        push_item(OP_PIXEL, 8'd7,   8'd7, 8'd7);
    endtask

    // Two pixels of a 2x2 frame, then a register write drops that frame; the
    // next frame must start from a clean window and clean positions.
    task automatic test_restart_mid_frame();
        set_geometry(2, 2);
        push_random(OP_PIXEL);
        push_random(OP_PIXEL);
        write_frame_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
        send_frame(0, 1'b0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and the item channel stalls. Half-way
    // through the frame the sender also pauses until every pixel is out.
    task automatic test_long_stall();
        int unsigned k;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        set_geometry(4, 6);
        long_hold_req = 1'b1;
        for (k = 0; k < 12; k++)
            push_random(OP_PIXEL);
        wait_blur_drained();
        for (k = 0; k < 12; k++)
            push_random(OP_PIXEL);
        for (k = 0; k < 5; k++)
            push_random(OP_DRAIN);
    endtask

    // Mostly small frames of random geometry with random content, some back
    // to back under one setting, some broken off and restarted.
    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned quota);
        int unsigned start, w, h;
        bit          broken;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        start = stream_items;
        while (stream_items - start < quota)
        begin
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       w = 0;
                    1:       w = $urandom_range(40, 17);
                    default: w = $urandom_range(6, 1);
                endcase
                case ($urandom_range(9))
                    0:       h = 0;
                    1:       h = $urandom_range(12, 6);
                    default: h = $urandom_range(5, 1);
                endcase
                set_geometry(w, h);
            end
            broken = ($urandom_range(9) == 0);
            send_frame(6, broken);
            if (broken)
                write_frame_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(cfg_width));
        end
    endtask

    // A zero width acting as one column and a height past the cap, all data
    // bits set, clamped to 4096 rows. The frame is broken off after a few
    // dozen pixels and dropped by a register write.
    task automatic test_extreme_geometry();
        int unsigned k;
        send_idle_pct  = 5;
        sink_stall_pct = 5;
        set_geometry(0, 8191);
        for (k = 0; k < 40; k++)
            push_random(OP_PIXEL);
        write_frame_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(0));
    endtask

    // ------------------------------------------------------------------------
    // Run sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        cfg_width  = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        for (i = 0; i < MAX_W; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        restart_frame();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_restart_mid_frame();
        test_long_stall();
        test_random_phase(0, 0, 250);
        test_random_phase(69, 0, 250);
        test_random_phase(0, 69, 250);
        test_random_phase(34, 34, 250);
        test_extreme_geometry();

        // Let the last pixels out, then keep watching for anything that should
        // not be there.
        wait_blur_drained();
        repeat (4 * PIPE_SETTLE) @(posedge clk);

        $display("Run covered %0d items and %0d checked blurred pixels over %0d frames,",
                 stream_items, blurred_checked, frames_closed);
        $display("from single-pixel frames up to 40 wide and 12 high plus a clamped column,");
        $display("with early drains, restarts, idle senders and stalled receivers.");
        if (mismatch_count == 0 && pending_blur_q.size() == 0)
            $display("box_blur_3x3_edge_aware_top: match");
        else
            $display("box_blur_3x3_edge_aware_top: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/bb3_pkg.sv
design/bb3_round_div.sv
design/box_blur_3x3_edge_aware_top.sv
dv/box_blur_3x3_edge_aware_top_tb.sv
